>>> rtl/sorted_priority_queue_core_macros.svh
// Assertion macros for the sorted priority queue core.
// Used by the checker that is bound to the top level.
`ifndef SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH

// Check a property on the rising clock, quiet while reset is held.
`define SPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check an implication on the rising clock, quiet while reset is held.
`define SPQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/spq_pkg.sv
// Shared types and constants of the sorted priority queue.
// No dependencies; used by the cell, the top level and the checker.
package spq_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_BITS = 32;
  localparam int KW       = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int TAG_W    = 16;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } spq_status_e;

  typedef struct packed {
    logic enq;
    logic deq;
  } spq_ctrl_t;

endpackage

>>> rtl/sorted_priority_queue_core.sv
// Sorted min priority queue: a chain of spq_cell slots, smallest key first.
// The result of each accepted item is registered on the output register in the next cycle.
// Throughput: one item per cycle while out_stall_i does not hold a result; every cell compares and shifts in parallel.
// Reset clears the fill count and the output valid; slot contents stay
// undefined and are never read until written, so there is no clearing pass.
module sorted_priority_queue_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       cmd_i,
  input  logic [31:0]                key_i,
  input  logic [15:0]                tag_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic [31:0]                out_key_o,
  output logic [15:0]                out_tag_o,
  output logic [6:0]                 count_o
);
  import spq_pkg::*;

  logic [CNT_W-1:0]    fill_q, fill_d;
  logic                out_valid_q;
  spq_status_e         status_q, status_d;
  logic [31:0]         out_key_q, out_key_d;
  logic [15:0]         out_tag_q, out_tag_d;
  logic [6:0]          count_q;

  logic                accept, empty, full;
  spq_ctrl_t           ctrl;
  logic [KW-1:0]       new_key;
  logic [CAPACITY-1:0] occ, ins;
  logic [KW-1:0]       keys [CAPACITY];
  logic [TAG_W-1:0]    tags [CAPACITY];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign empty      = (fill_q == '0);
  assign full       = (fill_q == CNT_W'(CAPACITY));
  assign new_key    = key_i[KW-1:0];

  assign ctrl.enq = accept && (cmd_i == CMD_ENQ) && !full;
  assign ctrl.deq = accept && (cmd_i == CMD_DEQ) && !empty;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      occ[i] = (CNT_W'(i) < fill_q);
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic             left_ins;
    logic [KW-1:0]    left_key, right_key;
    logic [TAG_W-1:0] left_tag, right_tag;

    if (g == 0) begin : g_head
      assign left_ins = 1'b0;
      assign left_key = '0;
      assign left_tag = '0;
    end else begin : g_body
      assign left_ins = ins[g-1];
      assign left_key = keys[g-1];
      assign left_tag = tags[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_key = '0;
      assign right_tag = '0;
    end else begin : g_mid
      assign right_key = keys[g+1];
      assign right_tag = tags[g+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (occ[g]),
      .new_key_i   (new_key),
      .new_tag_i   (tag_i),
      .left_ins_i  (left_ins),
      .left_key_i  (left_key),
      .left_tag_i  (left_tag),
      .right_key_i (right_key),
      .right_tag_i (right_tag),
      .ins_o       (ins[g]),
      .key_o       (keys[g]),
      .tag_o       (tags[g])
    );
  end

  always_comb begin
    fill_d    = fill_q;
    status_d  = ST_ENQ;
    out_key_d = '0;
    out_tag_d = '0;
    unique case (cmd_i)
      CMD_DEQ: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          status_d  = ST_DEQ;
          out_key_d = 32'(keys[0]);
          out_tag_d = tags[0];
          fill_d    = fill_q - CNT_W'(1);
        end
      end
      default: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          fill_d = fill_q + CNT_W'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        fill_q      <= fill_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      out_key_q <= out_key_d;
      out_tag_q <= out_tag_d;
      count_q   <= 7'(fill_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_key_o   = out_key_q;
  assign out_tag_o   = out_tag_q;
  assign count_o     = count_q;

endmodule

>>> rtl/spq_cell.sv
// One slot of the sorted shift chain: holds a key and a tag.
// Depends on spq_pkg for widths and the control struct.
module spq_cell (
  input  logic                    clk_i,
  input  spq_pkg::spq_ctrl_t      ctrl_i,
  input  logic                    occ_i,
  input  logic [spq_pkg::KW-1:0]  new_key_i,
  input  logic [spq_pkg::TAG_W-1:0] new_tag_i,
  input  logic                    left_ins_i,
  input  logic [spq_pkg::KW-1:0]  left_key_i,
  input  logic [spq_pkg::TAG_W-1:0] left_tag_i,
  input  logic [spq_pkg::KW-1:0]  right_key_i,
  input  logic [spq_pkg::TAG_W-1:0] right_tag_i,
  output logic                    ins_o,
  output logic [spq_pkg::KW-1:0]  key_o,
  output logic [spq_pkg::TAG_W-1:0] tag_o
);
  import spq_pkg::*;

  logic [KW-1:0]    key_q, key_d;
  logic [TAG_W-1:0] tag_q, tag_d;

  assign ins_o = !occ_i || (key_q >= new_key_i);

  always_comb begin
    key_d = key_q;
    tag_d = tag_q;
    priority if (ctrl_i.deq) begin
      key_d = right_key_i;
      tag_d = right_tag_i;
    end else if (ctrl_i.enq && left_ins_i) begin
      key_d = left_key_i;
      tag_d = left_tag_i;
    end else if (ctrl_i.enq && ins_o) begin
      key_d = new_key_i;
      tag_d = new_tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

  assign key_o = key_q;
  assign tag_o = tag_q;

endmodule

>>> rtl/spq_checker.sv
// Port-level checks of the sorted priority queue core, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_core_macros.svh.
`include "sorted_priority_queue_core_macros.svh"

module spq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [31:0] out_key_o,
  input logic [15:0] out_tag_o,
  input logic [6:0]  count_o
);
  import spq_pkg::*;

  `SPQ_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(out_key_o) && $stable(count_o), "stalled result changed")
  `SPQ_ASSERT_IMP(a_zero_payload, out_valid_o && (status_o != ST_DEQ), (out_key_o == '0) && (out_tag_o == '0), "payload not zero on non-dequeue")
  `SPQ_ASSERT_IMP(a_empty_count, out_valid_o && (status_o == ST_EMPTY), count_o == '0, "empty error with nonzero count")
  `SPQ_ASSERT_IMP(a_full_count, out_valid_o && (status_o == ST_FULL), count_o == 7'(CAPACITY), "full error with count not at capacity")

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (.*);

>>> dv/testbench.sv
// Self-checking testbench for sorted_priority_queue_core: directed and random
// enqueue/dequeue traffic, predicted by a sorted-store model kept here.
// Depends on spq_pkg for the sizes, the command codes and the status codes.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam logic [63:0] KEY_MASK = (KEY_BITS >= 64) ? {64{1'b1}}
                                                      : ((64'd1 << KEY_BITS) - 64'd1);

  typedef struct {
    spq_status_e status;
    logic [31:0] out_key;
    logic [15:0] out_tag;
    logic [6:0]  count;
  } queue_result_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        cmd_i       = CMD_ENQ;
  logic [31:0] key_i       = '0;
  logic [15:0] tag_i       = '0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  status_o;
  logic [31:0] out_key_o;
  logic [15:0] out_tag_o;
  logic [6:0]  count_o;

  logic [63:0] sorted_keys [CAPACITY];
  logic [15:0] sorted_tags [CAPACITY];
  int unsigned held;
  queue_result_t pending_results [$];
  int unsigned failures;
  bit          no_idle;

  sorted_priority_queue_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .key_i       (key_i),
    .tag_i       (tag_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .out_key_o   (out_key_o),
    .out_tag_o   (out_tag_o),
    .count_o     (count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

  // Store runs from the largest key at slot 0 to the smallest at slot held-1.
  function automatic queue_result_t apply_queue_op(logic cmd, logic [31:0] key,
                                                   logic [15:0] tag);
    queue_result_t r;
    logic [63:0]   k;
    int unsigned   pos;
    r.out_key = '0;
    r.out_tag = '0;
    if (cmd == CMD_DEQ) begin
      if (held == 0) begin
        r.status = ST_EMPTY;
      end else begin
        held--;
        r.out_key = sorted_keys[held][31:0];
        r.out_tag = sorted_tags[held];
        r.status  = ST_DEQ;
      end
    end else if (held >= CAPACITY) begin
      r.status = ST_FULL;
    end else begin
      k   = {32'd0, key} & KEY_MASK;
      pos = held;
      for (int i = int'(held) - 1; i >= 0; i--) begin
        if (sorted_keys[i] < k) pos = i;
      end
      for (int i = int'(held); i > int'(pos); i--) begin
        sorted_keys[i] = sorted_keys[i-1];
        sorted_tags[i] = sorted_tags[i-1];
      end
      sorted_keys[pos] = k;
      sorted_tags[pos] = tag;
      held++;
      r.status = ST_ENQ;
    end
    r.count = held[6:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      pending_results.push_back(apply_queue_op(cmd_i, key_i, tag_i));
  end

  always @(posedge clk_i) begin
    if (rst_ni)
      out_stall_i <= !no_idle && ($urandom_range(0, 99) < 36);
  end

  always @(posedge clk_i) begin
    queue_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no item waiting: status %0d", status_o);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          failures++;
        end
        if (out_key_o !== want.out_key) begin
          $error("out_key: expected %0h, actual %0h", want.out_key, out_key_o);
          failures++;
        end
        if (out_tag_o !== want.out_tag) begin
          $error("out_tag: expected %0h, actual %0h", want.out_tag, out_tag_o);
          failures++;
        end
        if (count_o !== want.count) begin
          $error("count: expected %0d, actual %0d", want.count, count_o);
          failures++;
        end
      end
    end
  end

  task automatic send_item(logic cmd, logic [31:0] key, logic [15:0] tag);
    while (!no_idle && ($urandom_range(0, 99) < 36)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    key_i      <= key;
    tag_i      <= tag;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_key();
    unique case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2, 3, 4: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_dequeue();
    send_item(CMD_DEQ, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(CMD_DEQ, 32'h0, 16'h0);
  endtask

  task automatic test_key_extremes();
    send_item(CMD_ENQ, 32'h0, 16'h0);
    send_item(CMD_ENQ, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(CMD_ENQ, 32'h8000_0001, 16'h5AA5);
    send_item(CMD_DEQ, 32'h0, 16'h0);
    send_item(CMD_DEQ, 32'h0, 16'h0);
    send_item(CMD_DEQ, 32'h0, 16'h0);
    send_item(CMD_DEQ, 32'h0, 16'h0);
  endtask

  task automatic test_equal_keys();
    send_item(CMD_ENQ, 32'd5, 16'd1);
    send_item(CMD_ENQ, 32'd5, 16'd2);
    send_item(CMD_ENQ, 32'd9, 16'd3);
    send_item(CMD_ENQ, 32'd5, 16'd4);
    send_item(CMD_ENQ, 32'd4, 16'd5);
    repeat (6) send_item(CMD_DEQ, $urandom, 16'($urandom_range(0, 65535)));
  endtask

  task automatic test_random_ops(int unsigned n, int unsigned enq_pct);
    repeat (n) begin
      if ($urandom_range(0, 99) < enq_pct)
        send_item(CMD_ENQ, pick_key(), 16'($urandom_range(0, 65535)));
      else
        send_item(CMD_DEQ, $urandom, 16'($urandom_range(0, 65535)));
    end
  endtask

  task automatic test_fill_and_drain();
    test_random_ops(300, 85);
    test_random_ops(300, 15);
  endtask

  task automatic test_no_idle_stretch();
    no_idle = 1'b1;
    test_random_ops(250, 80);
    test_random_ops(150, 25);
    no_idle = 1'b0;
  endtask

  initial begin
    held     = 0;
    failures = 0;
    no_idle  = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_dequeue();
    test_key_extremes();
    test_equal_keys();
    test_fill_and_drain();
    test_random_ops(400, 50);
    test_no_idle_stretch();
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_core.sv
rtl/spq_checker.sv
dv/testbench.sv
